FILE: hw/rtl/rcdq_pkg.sv
// rcdq_pkg: shared constants, request codes and types of the recentering deque
// no dependencies; compiled first
`default_nettype none

package rcdq_pkg;

  localparam int DEF_DEPTH  = 256;
  localparam int CFG_W      = 9;
  localparam int SIZE_RESET = 256;
  localparam int SIZE_MIN   = 2;
  localparam int KIND_W     = 2;
  localparam int DATA_W     = 32;
  localparam int ENTRY_W    = 2 * DATA_W;
  localparam int FQ_DEPTH   = 2;

  localparam logic [KIND_W-1:0] KIND_PUSH_TAIL = 2'd0;
  localparam logic [KIND_W-1:0] KIND_PUSH_HEAD = 2'd1;
  localparam logic [KIND_W-1:0] KIND_POP       = 2'd2;

  typedef enum logic [1:0] {
    OP_PUSH_TAIL,
    OP_PUSH_HEAD,
    OP_POP,
    OP_NONE
  } op_t;

  typedef struct packed {
    op_t                      op;
    logic        [DATA_W-1:0] item_ref;
    logic signed [DATA_W-1:0] item_value;
  } req_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MOVE,
    ST_PUSH,
    ST_POP
  } state_t;

endpackage

`default_nettype wire

FILE: hw/rtl/rcdq_if.sv
// rcdq_if: valid/ready channel interfaces for requests and results
// depends on rcdq_pkg for field widths
`default_nettype none

interface rcdq_in_if;
  import rcdq_pkg::*;
  logic                      valid;
  logic                      ready;
  logic        [KIND_W-1:0]  kind;
  logic        [DATA_W-1:0]  item_ref;
  logic signed [DATA_W-1:0]  item_value;

  modport source (output valid, kind, item_ref, item_value, input ready);
  modport sink   (input valid, kind, item_ref, item_value, output ready);
endinterface

interface rcdq_out_if;
  import rcdq_pkg::*;
  logic                      valid;
  logic                      ready;
  logic                      status;
  logic                      popped;
  logic        [DATA_W-1:0]  out_ref;
  logic signed [DATA_W-1:0]  out_value;
  logic                      empty_after;

  modport source (output valid, status, popped, out_ref, out_value, empty_after,
                  input ready);
  modport sink   (input valid, status, popped, out_ref, out_value, empty_after,
                  output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/recentering_deque_unit.sv
// recentering_deque_unit: top level of the recentering deque
// depends on rcdq_pkg, rcdq_if, rcdq_front, rcdq_back (with rcdq_ram)
//
//  channel  direction  handshake          payload
//  in_ch    sink       valid/ready        kind, item_ref, item_value
//  out_ch   source     valid/ready        status, popped, out_ref, out_value, empty_after
//  cfg      write      cfg_we             cfg_wdata (queue_size)
//
// requests pass through the front queue; a push finishes in idle, a pop reads first (ram read port)
// push at an edge first moves each of the len live entries, one a cycle, in the move state
// when they have to move, then writes in the push state (none move when they already sit at the new start)
// one result per request; a two-entry request queue and the result register
// let each side stall on its own
// reset is synchronous; entry ram is not cleared, no clearing pass
`default_nettype none

module recentering_deque_unit
  import rcdq_pkg::*;
#(
  parameter int DEPTH = DEF_DEPTH
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  rcdq_in_if.sink                in_ch,
  rcdq_out_if.source             out_ch,
  input  wire logic              cfg_we,
  input  wire logic [CFG_W-1:0]  cfg_wdata
);

  logic req_valid;
  logic req_take;
  req_t req;

  rcdq_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .req_valid (req_valid),
    .req       (req),
    .req_take  (req_take)
  );

  rcdq_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req       (req),
    .req_take  (req_take),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/rcdq_ram.sv
// rcdq_ram: generic simple dual-port ram, one write and one registered read port
// depends on rcdq_pkg for default sizes
`default_nettype none

module rcdq_ram
  import rcdq_pkg::*;
#(
  parameter int WIDTH = ENTRY_W,
  parameter int DEPTH = DEF_DEPTH
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/rcdq_front.sv
// rcdq_front: accepts requests, decodes the kind and holds them in a short queue
// depends on rcdq_pkg and rcdq_if
`default_nettype none

module rcdq_front
  import rcdq_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  rcdq_in_if.sink    in_ch,
  output      logic  req_valid,
  output      req_t  req,
  input  wire logic  req_take
);

  localparam int PW = (FQ_DEPTH > 1) ? $clog2(FQ_DEPTH) : 1;
  localparam int CW = $clog2(FQ_DEPTH + 1);

  req_t            slot_r [FQ_DEPTH];
  logic [PW-1:0]   wptr_r, wptr_nxt;
  logic [PW-1:0]   rptr_r, rptr_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  op_t             op_in;
  logic            push;

  always_comb begin
    unique case (in_ch.kind)
      KIND_PUSH_TAIL: op_in = OP_PUSH_TAIL;
      KIND_PUSH_HEAD: op_in = OP_PUSH_HEAD;
      KIND_POP:       op_in = OP_POP;
      default:        op_in = OP_NONE;
    endcase
  end

  assign in_ch.ready = (cnt_r != CW'(FQ_DEPTH));
  assign push        = in_ch.valid && in_ch.ready;
  assign req_valid   = (cnt_r != '0);
  assign req         = slot_r[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (push) begin
      wptr_nxt = (wptr_r == PW'(FQ_DEPTH - 1)) ? '0 : wptr_r + PW'(1);
    end
    if (req_take) begin
      rptr_nxt = (rptr_r == PW'(FQ_DEPTH - 1)) ? '0 : rptr_r + PW'(1);
    end
    if (push && !req_take) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (!push && req_take) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wptr_r] <= '{op: op_in, item_ref: in_ch.item_ref, item_value: in_ch.item_value};
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/rcdq_back.sv
// rcdq_back: executes requests on the entry ram, recenters the live entries,
//   keeps head, tail and size, and drives the result register
// depends on rcdq_pkg, rcdq_if and rcdq_ram
`default_nettype none

module rcdq_back
  import rcdq_pkg::*;
#(
  parameter int DEPTH = DEF_DEPTH
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              req_valid,
  input  wire req_t              req,
  output      logic              req_take,
  rcdq_out_if.source             out_ch,
  input  wire logic              cfg_we,
  input  wire logic [CFG_W-1:0]  cfg_wdata
);

  localparam int IW       = $clog2(DEPTH + 1);
  localparam int AW       = $clog2(DEPTH);
  localparam int CW       = (IW > CFG_W) ? IW : CFG_W;
  localparam int RST_SIZE = (SIZE_RESET > DEPTH) ? DEPTH : SIZE_RESET;

  state_t                  state_r, state_nxt;
  logic [IW-1:0]           size_r, size_nxt;
  logic [IW-1:0]           head_r, head_nxt;
  logic [IW-1:0]           tail_r, tail_nxt;
  logic [IW-1:0]           src_r, src_nxt;
  logic [IW-1:0]           dst_r, dst_nxt;
  logic [IW-1:0]           cnt_r, cnt_nxt;
  logic                    desc_r, desc_nxt;
  logic                    wpend_r, wpend_nxt;

  logic                    out_valid_r, out_valid_nxt;
  logic                    status_r, status_nxt;
  logic                    popped_r, popped_nxt;
  logic [DATA_W-1:0]       oref_r, oref_nxt;
  logic signed [DATA_W-1:0] oval_r, oval_nxt;
  logic                    empty_r, empty_nxt;

  logic                    ram_we, ram_re;
  logic [AW-1:0]           ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0]      ram_wdata, ram_rdata;

  logic [IW-1:0]           len, room, nh_tail, nh_head, nh, head_dec;
  logic                    at_right, at_left, out_free, out_load, start_move;
  logic [CW-1:0]           cfg_ext;
  logic [IW-1:0]           size_cfg;

  rcdq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // recentering targets
  assign len      = tail_r - head_r;
  assign room     = size_r - len;
  assign nh_tail  = room >> 1;
  assign nh_head  = (room <= IW'(2)) ? IW'(1) : (room >> 1);
  assign head_dec = head_r - IW'(1);
  assign at_right = (tail_r >= size_r - IW'(1));
  assign at_left  = (head_r == '0);
  assign out_free = !out_valid_r || out_ch.ready;

  always_comb begin
    cfg_ext = CW'(cfg_wdata);
    if (cfg_ext < CW'(SIZE_MIN)) begin
      size_cfg = IW'(SIZE_MIN);
    end else if (cfg_ext > CW'(DEPTH)) begin
      size_cfg = IW'(DEPTH);
    end else begin
      size_cfg = IW'(cfg_ext);
    end
  end

  always_comb begin
    state_nxt  = state_r;
    size_nxt   = size_r;
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    src_nxt    = src_r;
    dst_nxt    = dst_r;
    cnt_nxt    = cnt_r;
    desc_nxt   = desc_r;
    wpend_nxt  = 1'b0;
    status_nxt = status_r;
    popped_nxt = popped_r;
    oref_nxt   = oref_r;
    oval_nxt   = oval_r;
    empty_nxt  = empty_r;
    out_load   = 1'b0;
    req_take   = 1'b0;
    start_move = 1'b0;
    nh         = nh_tail;
    ram_we     = 1'b0;
    ram_waddr  = tail_r[AW-1:0];
    ram_wdata  = {req.item_ref, req.item_value};
    ram_re     = 1'b0;
    ram_raddr  = head_r[AW-1:0];

    unique case (state_r)
      ST_IDLE: begin
        if (req_valid) begin
          unique case (req.op)
            OP_PUSH_TAIL: begin
              if (at_right && !at_left) begin
                start_move = 1'b1;
                nh         = nh_tail;
              end else if (out_free) begin
                out_load   = 1'b1;
                req_take   = 1'b1;
                popped_nxt = 1'b0;
                oref_nxt   = '0;
                oval_nxt   = '0;
                if (at_right) begin
                  status_nxt = 1'b1;
                end else begin
                  status_nxt = 1'b0;
                  ram_we     = 1'b1;
                  ram_waddr  = tail_r[AW-1:0];
                  tail_nxt   = tail_r + IW'(1);
                end
              end
            end
            OP_PUSH_HEAD: begin
              if (at_left && !at_right) begin
                start_move = 1'b1;
                nh         = nh_head;
              end else if (out_free) begin
                out_load   = 1'b1;
                req_take   = 1'b1;
                popped_nxt = 1'b0;
                oref_nxt   = '0;
                oval_nxt   = '0;
                if (at_left) begin
                  status_nxt = 1'b1;
                end else begin
                  status_nxt = 1'b0;
                  ram_we     = 1'b1;
                  ram_waddr  = head_dec[AW-1:0];
                  head_nxt   = head_dec;
                end
              end
            end
            OP_POP: begin
              if (head_r < tail_r) begin
                ram_re    = 1'b1;
                ram_raddr = head_r[AW-1:0];
                state_nxt = ST_POP;
              end else if (out_free) begin
                out_load   = 1'b1;
                req_take   = 1'b1;
                status_nxt = 1'b0;
                popped_nxt = 1'b0;
                oref_nxt   = '0;
                oval_nxt   = '0;
              end
            end
            OP_NONE: begin
              if (out_free) begin
                out_load   = 1'b1;
                req_take   = 1'b1;
                status_nxt = 1'b0;
                popped_nxt = 1'b0;
                oref_nxt   = '0;
                oval_nxt   = '0;
              end
            end
          endcase
          if (start_move) begin
            head_nxt  = nh;
            tail_nxt  = nh + len;
            desc_nxt  = (nh > head_r);
            src_nxt   = (nh > head_r) ? head_r + len - IW'(1) : head_r;
            dst_nxt   = (nh > head_r) ? nh + len - IW'(1) : nh;
            cnt_nxt   = (nh == head_r) ? '0 : len;
            state_nxt = ST_MOVE;
          end
        end
      end

      // copy one entry a cycle, read ahead of write, direction keeps overlap intact
      ST_MOVE: begin
        if (cnt_r != '0) begin
          ram_re    = 1'b1;
          ram_raddr = src_r[AW-1:0];
          src_nxt   = desc_r ? src_r - IW'(1) : src_r + IW'(1);
          cnt_nxt   = cnt_r - IW'(1);
          wpend_nxt = 1'b1;
        end else begin
          state_nxt = ST_PUSH;
        end
        if (wpend_r) begin
          ram_we    = 1'b1;
          ram_waddr = dst_r[AW-1:0];
          ram_wdata = ram_rdata;
          dst_nxt   = desc_r ? dst_r - IW'(1) : dst_r + IW'(1);
        end
      end

      ST_PUSH: begin
        if (out_free) begin
          out_load   = 1'b1;
          req_take   = 1'b1;
          status_nxt = 1'b0;
          popped_nxt = 1'b0;
          oref_nxt   = '0;
          oval_nxt   = '0;
          ram_we     = 1'b1;
          state_nxt  = ST_IDLE;
          if (req.op == OP_PUSH_TAIL) begin
            ram_waddr = tail_r[AW-1:0];
            tail_nxt  = tail_r + IW'(1);
          end else begin
            ram_waddr = head_dec[AW-1:0];
            head_nxt  = head_dec;
          end
        end
      end

      ST_POP: begin
        if (out_free) begin
          out_load   = 1'b1;
          req_take   = 1'b1;
          status_nxt = 1'b0;
          popped_nxt = 1'b1;
          oref_nxt   = ram_rdata[ENTRY_W-1:DATA_W];
          oval_nxt   = ram_rdata[DATA_W-1:0];
          head_nxt   = head_r + IW'(1);
          state_nxt  = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (out_load) begin
      empty_nxt = (head_nxt == tail_nxt);
    end

    // size write empties the queue
    if (cfg_we) begin
      size_nxt = size_cfg;
      head_nxt = size_cfg >> 1;
      tail_nxt = size_cfg >> 1;
    end
  end

  assign out_valid_nxt = out_load ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      size_r      <= IW'(RST_SIZE);
      head_r      <= IW'(RST_SIZE / 2);
      tail_r      <= IW'(RST_SIZE / 2);
      cnt_r       <= '0;
      desc_r      <= 1'b0;
      wpend_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      size_r      <= size_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      cnt_r       <= cnt_nxt;
      desc_r      <= desc_nxt;
      wpend_r     <= wpend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    src_r    <= src_nxt;
    dst_r    <= dst_nxt;
    status_r <= status_nxt;
    popped_r <= popped_nxt;
    oref_r   <= oref_nxt;
    oval_r   <= oval_nxt;
    empty_r  <= empty_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = status_r;
  assign out_ch.popped      = popped_r;
  assign out_ch.out_ref     = oref_r;
  assign out_ch.out_value   = oval_r;
  assign out_ch.empty_after = empty_r;

`ifndef ASSERT_OFF
  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    head_r <= tail_r)
    else $error("head index passed tail index");

  a_bound: assert property (@(posedge clk) disable iff (!rst_n)
    tail_r <= size_r)
    else $error("tail index beyond active size");

  a_take: assert property (@(posedge clk) disable iff (!rst_n)
    req_take |-> req_valid)
    else $error("request taken from empty queue");

  a_move_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MOVE && cnt_r == '0) |=> (state_r == ST_PUSH))
    else $error("move did not hand over to push");

  a_ram_ports: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && ram_re) |-> (state_r == ST_MOVE && ram_waddr != ram_raddr))
    else $error("ram read and write collide");
`endif

endmodule

`default_nettype wire

FILE: dv/recentering_deque_unit_tb.sv
`timescale 1ns / 100ps
// recentering_deque_unit_tb: directed table then random phases over queue sizes
// checks every result against an in-bench deque model or a pinned table result; needs rcdq_pkg, rcdq_if, the rtl

module recentering_deque_unit_tb;
  import rcdq_pkg::*;

  typedef struct packed {
    logic                     status;
    logic                     popped;
    logic        [DATA_W-1:0] out_ref;
    logic signed [DATA_W-1:0] out_value;
    logic                     empty_after;
  } deque_rsp_t;

  typedef struct packed {
    logic       typed;
    deque_rsp_t rsp;
  } pinned_rsp_t;

  typedef struct packed {
    logic                     set_size;
    logic        [CFG_W-1:0]  size;
    op_t                      op;
    logic        [DATA_W-1:0] handle;
    logic signed [DATA_W-1:0] word;
    logic                     typed;
    deque_rsp_t               rsp;
  } dir_row_t;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_wdata;

  rcdq_in_if  in_ch ();
  rcdq_out_if out_ch ();

  recentering_deque_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  logic [ENTRY_W-1:0] q_store [DEF_DEPTH];
  logic [CFG_W-1:0]   q_size;
  logic [CFG_W-1:0]   q_head;
  logic [CFG_W-1:0]   q_tail;

  deque_rsp_t  expected_rsp_q [$];
  pinned_rsp_t pinned_q [$];
  int          mismatches;
  int          burst_left;
  logic        sender_idles;

  initial begin
    clk = 1'b0;
  end

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #100_000_000;
    $display("[recentering_deque_unit] ERROR");
    $finish;
  end

  // move live entries so that they start at new_head, copy order safe for overlap
  function automatic void recenter(input logic [CFG_W-1:0] new_head);
    logic [CFG_W-1:0] len;
    int               i;
    len = q_tail - q_head;
    if (new_head < q_head) begin
      for (i = 0; i < int'(len); i++) q_store[new_head + i] = q_store[q_head + i];
    end else begin
      for (i = int'(len) - 1; i >= 0; i--) q_store[new_head + i] = q_store[q_head + i];
    end
    q_head = new_head;
    q_tail = new_head + len;
  endfunction

  function automatic deque_rsp_t deque_step(input req_t r);
    deque_rsp_t       rsp;
    logic [CFG_W-1:0] room;
    logic             ok;
    logic             at_right;
    rsp      = '0;
    ok       = 1'b1;
    room     = q_size - (q_tail - q_head);
    at_right = ({1'b0, q_tail} + 10'd1) >= {1'b0, q_size};
    case (r.op)
      OP_PUSH_TAIL: begin
        if (at_right) begin
          if (q_head == '0) ok = 1'b0;
          else recenter(room >> 1);
        end
        if (ok && q_tail < q_size) begin
          q_store[q_tail] = {r.item_ref, r.item_value};
          q_tail = q_tail + 1'b1;
        end else begin
          rsp.status = 1'b1;
        end
      end
      OP_PUSH_HEAD: begin
        if (q_head == '0) begin
          if (at_right) ok = 1'b0;
          else recenter((room <= 2) ? 9'd1 : (room >> 1));
        end
        if (ok && q_head != '0) begin
          q_head = q_head - 1'b1;
          q_store[q_head] = {r.item_ref, r.item_value};
        end else begin
          rsp.status = 1'b1;
        end
      end
      OP_POP: begin
        if (q_head < q_tail) begin
          rsp.popped = 1'b1;
          {rsp.out_ref, rsp.out_value} = q_store[q_head];
          q_head = q_head + 1'b1;
        end
      end
      default: ;
    endcase
    rsp.empty_after = (q_head == q_tail);
    return rsp;
  endfunction

  task automatic check_field(input string name, input logic [DATA_W-1:0] want,
                             input logic [DATA_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%08h, got 0x%08h", name, want, got);
      mismatches++;
    end
  endtask

  // request acceptance feeds the model, result acceptance is checked
  always @(posedge clk) begin : monitor
    req_t        req;
    pinned_rsp_t pin;
    deque_rsp_t  want;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        req.op         = op_t'(in_ch.kind);
        req.item_ref   = in_ch.item_ref;
        req.item_value = in_ch.item_value;
        pin  = pinned_q.pop_front();
        want = deque_step(req);
        expected_rsp_q.push_back(pin.typed ? pin.rsp : want);
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_rsp_q.size() == 0) begin
          $error("result with no request outstanding");
          mismatches++;
        end else begin
          want = expected_rsp_q.pop_front();
          check_field("status", DATA_W'(want.status), DATA_W'(out_ch.status));
          check_field("popped", DATA_W'(want.popped), DATA_W'(out_ch.popped));
          check_field("out_ref", want.out_ref, out_ch.out_ref);
          check_field("out_value", want.out_value, out_ch.out_value);
          check_field("empty_after", DATA_W'(want.empty_after),
                      DATA_W'(out_ch.empty_after));
        end
      end
    end
  end

  // receiver stall pattern, switching between modes
  initial begin : receiver
    int mode;
    int hold;
    int cnt;
    mode = 0;
    hold = 0;
    cnt  = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold == 0) begin
        mode = $urandom_range(0, 3);
        hold = $urandom_range(20, 200);
      end
      hold--;
      cnt++;
      case (mode)
        0:       out_ch.ready <= 1'b1;
        1:       out_ch.ready <= 1'($urandom_range(0, 1));
        2:       out_ch.ready <= (cnt % 7) > 1;
        default: out_ch.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  task automatic send_request(input req_t r, input logic typed, input deque_rsp_t rsp);
    int gap;
    gap = 0;
    if (sender_idles) begin
      if (burst_left == 0) begin
        gap        = $urandom_range(1, 6);
        burst_left = $urandom_range(1, 16);
      end else begin
        burst_left--;
      end
    end
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.kind       <= r.op;
    in_ch.item_ref   <= r.item_ref;
    in_ch.item_value <= r.item_value;
    pinned_q.push_back('{typed, rsp});
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (expected_rsp_q.size() != 0);
  endtask

  task automatic set_queue_size(input logic [CFG_W-1:0] v);
    drain();
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (v < SIZE_MIN) q_size = CFG_W'(SIZE_MIN);
    else if (v > DEF_DEPTH) q_size = CFG_W'(DEF_DEPTH);
    else q_size = v;
    q_head = q_size >> 1;
    q_tail = q_size >> 1;
  endtask

  initial begin : stimulus
    dir_row_t         dir_rows [26];
    logic [CFG_W-1:0] phase_sizes [14];
    req_t             r;
    int               k;
    int               p;
    int               n;
    int               pick;
    int               split;

    rst_n            <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_wdata        <= '0;
    in_ch.valid      <= 1'b0;
    in_ch.kind       <= '0;
    in_ch.item_ref   <= '0;
    in_ch.item_value <= '0;
    mismatches   = 0;
    burst_left   = 0;
    sender_idles = 1'b1;
    q_size = CFG_W'(SIZE_RESET);
    q_head = CFG_W'(SIZE_RESET / 2);
    q_tail = CFG_W'(SIZE_RESET / 2);

    dir_rows = '{
      '{1'b0, 9'd0,   OP_POP,       32'h0,        32'h0,        1'b1, '{0, 0, 0, 0, 1}},
      '{1'b0, 9'd0,   OP_NONE,      32'hffffffff, 32'hffffffff, 1'b1, '{0, 0, 0, 0, 1}},
      '{1'b0, 9'd0,   OP_PUSH_TAIL, 32'hffffffff, 32'h7fffffff, 1'b1, '{0, 0, 0, 0, 0}},
      '{1'b0, 9'd0,   OP_PUSH_HEAD, 32'h0,        32'h80000000, 1'b1, '{0, 0, 0, 0, 0}},
      '{1'b0, 9'd0,   OP_POP,       32'h0,        32'h0,        1'b1,
        '{0, 1, 32'h0, 32'h80000000, 0}},
      '{1'b0, 9'd0,   OP_POP,       32'h0,        32'h0,        1'b1,
        '{0, 1, 32'hffffffff, 32'h7fffffff, 1}},
      // size below minimum, tail edge recentering then full
      '{1'b1, 9'd0,   OP_PUSH_TAIL, 32'h12345678, 32'h00000001, 1'b0, '0},
      '{1'b0, 9'd0,   OP_PUSH_TAIL, 32'h9abcdef0, 32'hfffffffe, 1'b0, '0},
      '{1'b0, 9'd0,   OP_PUSH_TAIL, 32'h1,        32'h1,        1'b1, '{1, 0, 0, 0, 0}},
      '{1'b0, 9'd0,   OP_PUSH_HEAD, 32'h2,        32'h2,        1'b1, '{1, 0, 0, 0, 0}},
      '{1'b0, 9'd0,   OP_POP,       32'h0,        32'h0,        1'b0, '0},
      '{1'b0, 9'd0,   OP_POP,       32'h0,        32'h0,        1'b0, '0},
      '{1'b0, 9'd0,   OP_POP,       32'h0,        32'h0,        1'b1, '{0, 0, 0, 0, 1}},
      '{1'b1, 9'd1,   OP_PUSH_HEAD, 32'hcafe0001, 32'h5a5a5a5a, 1'b0, '0},
      // size above maximum
      '{1'b1, 9'd511, OP_PUSH_TAIL, 32'h0f0f0f0f, 32'h7fffffff, 1'b0, '0},
      // head edge recentering with little room, then both edges full
      '{1'b1, 9'd4,   OP_PUSH_HEAD, 32'ha0000001, 32'h00000011, 1'b0, '0},
      '{1'b0, 9'd0,   OP_PUSH_HEAD, 32'ha0000002, 32'h00000022, 1'b0, '0},
      '{1'b0, 9'd0,   OP_PUSH_HEAD, 32'ha0000003, 32'h80000001, 1'b0, '0},
      '{1'b0, 9'd0,   OP_PUSH_HEAD, 32'ha0000004, 32'h00000044, 1'b1, '{1, 0, 0, 0, 0}},
      '{1'b0, 9'd0,   OP_PUSH_TAIL, 32'ha0000005, 32'h00000055, 1'b1, '{1, 0, 0, 0, 0}},
      '{1'b0, 9'd0,   OP_POP,       32'h0,        32'h0,        1'b0, '0},
      '{1'b0, 9'd0,   OP_POP,       32'h0,        32'h0,        1'b0, '0},
      '{1'b0, 9'd0,   OP_PUSH_TAIL, 32'ha0000006, 32'hdeadbeef, 1'b0, '0},
      '{1'b0, 9'd0,   OP_POP,       32'h0,        32'h0,        1'b0, '0},
      '{1'b0, 9'd0,   OP_POP,       32'h0,        32'h0,        1'b0, '0},
      '{1'b0, 9'd0,   OP_POP,       32'h0,        32'h0,        1'b1, '{0, 0, 0, 0, 1}}
    };

    phase_sizes = '{9'd3, 9'd256, 9'd2, 9'd5, 9'd511, 9'd4, 9'd1,
                    9'd16, 9'd257, 9'd7, 9'd0, 9'd100, 9'd8, 9'd0};
    phase_sizes[13] = 9'($urandom_range(2, 40));

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (k = 0; k < 26; k++) begin
      if (dir_rows[k].set_size) set_queue_size(dir_rows[k].size);
      r.op         = dir_rows[k].op;
      r.item_ref   = dir_rows[k].handle;
      r.item_value = dir_rows[k].word;
      send_request(r, dir_rows[k].typed, dir_rows[k].rsp);
    end

    for (p = 0; p < 14; p++) begin
      set_queue_size(phase_sizes[p]);
      sender_idles = (p % 3) != 2;
      n     = (phase_sizes[p] >= 64) ? 250 : 100;
      split = (p % 3 == 0) ? 82 : ((p % 3 == 1) ? 40 : 61);
      for (k = 0; k < n; k++) begin
        pick = $urandom_range(0, 99);
        // push heavy first, pop heavy toward the end of the phase
        if (pick < 2) r.op = OP_NONE;
        else if (k >= (n * 3) / 5) r.op = (pick < 60) ? OP_POP :
                                          ((pick < 80) ? OP_PUSH_TAIL : OP_PUSH_HEAD);
        else if (pick < 22) r.op = OP_POP;
        else r.op = (pick < split) ? OP_PUSH_TAIL : OP_PUSH_HEAD;
        r.item_ref   = $urandom;
        r.item_value = $urandom;
        send_request(r, 1'b0, '0);
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("[recentering_deque_unit] OK");
    end else begin
      $display("[recentering_deque_unit] ERROR");
    end
    $finish;
  end

endmodule
